// File: rtl/mbet_pkg.sv
// Shared types, constants and helpers for the Mandelbrot escape-time unit.
`default_nettype none

package mbet_pkg;

    // Fixed field widths
    localparam int VAL_W     = 32;              // z, c and origin values
    localparam int STEP_W    = 31;              // per-pixel step registers
    localparam int ITER_W    = 16;              // iteration counter
    localparam int PROD_FW   = 2 * VAL_W;       // full square/cross product
    localparam int SAT_W     = PROD_FW + 2;     // headroom before saturation
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int OUT_W     = ITER_W + 2 * VAL_W;

    // Parameter defaults
    localparam int DEF_COORD_BITS = 12;
    localparam int DEF_FRAC_BITS  = 27;

    // Register reset values
    localparam logic signed [VAL_W-1:0] RST_ORIGIN_RE = -32'sd268435456;
    localparam logic signed [VAL_W-1:0] RST_ORIGIN_IM = 32'sd134217728;
    localparam logic [STEP_W-1:0]       RST_STEP_RE   = 31'd262144;
    localparam logic [STEP_W-1:0]       RST_STEP_IM   = 31'd262144;
    localparam logic [ITER_W-1:0]       RST_MAX_ITER  = 16'd255;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_RE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_IM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_MUL,
        ST_EVAL
    } t_state;

    typedef struct packed {
        logic load;     // capture pixel, form coordinate products
        logic seed;     // form c, clear z and count
        logic mul;      // register squares and cross product of z
        logic step;     // write new z, advance count
        logic publish;  // load the result word
    } t_dp_cmd;

    typedef struct packed {
        logic escaped;
        logic at_limit;
    } t_dp_sts;

    // Clamp a wide signed value to the signed range of VAL_W bits.
    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SAT_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (!v[SAT_W-1] && (|v[SAT_W-2:VAL_W-1])) begin
            r = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (v[SAT_W-1] && !(&v[SAT_W-2:VAL_W-1])) begin
            r = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mbet_ctrl.sv
// Sequencer for the escape-time unit: handshakes and datapath commands.
`default_nettype none

module mbet_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire mbet_pkg::t_dp_sts i_sts,
    output mbet_pkg::t_dp_cmd     o_cmd
);
    import mbet_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_take;
    logic   w_done;

    assign w_out_take  = r_out_valid && i_out_ready;
    assign w_done      = i_sts.escaped || i_sts.at_limit;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !w_out_take;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEED;
                end
            end
            ST_SEED: begin
                o_cmd.seed = 1'b1;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_EVAL;
            end
            ST_EVAL: begin
                if (w_done) begin
                    // hold until the result register is free
                    if (!r_out_valid || w_out_take) begin
                        o_cmd.publish = 1'b1;
                        n_out_valid   = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/mbet_dp.sv
// Datapath of the escape-time unit: point mapping, z update and escape test.
`default_nettype none

module mbet_dp #(
    parameter int COORD_BITS = mbet_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = mbet_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                  i_clk,
    input  wire mbet_pkg::t_dp_cmd                     i_cmd,
    output mbet_pkg::t_dp_sts                          o_sts,
    input  wire logic [COORD_BITS-1:0]                 i_pixel_x,
    input  wire logic [COORD_BITS-1:0]                 i_pixel_y,
    input  wire logic signed [mbet_pkg::VAL_W-1:0]     i_origin_re,
    input  wire logic signed [mbet_pkg::VAL_W-1:0]     i_origin_im,
    input  wire logic [mbet_pkg::STEP_W-1:0]           i_step_re,
    input  wire logic [mbet_pkg::STEP_W-1:0]           i_step_im,
    input  wire logic [mbet_pkg::ITER_W-1:0]           i_max_iter,
    output logic                                       o_inside_res,
    output logic [mbet_pkg::ITER_W-1:0]                o_iterations,
    output logic signed [mbet_pkg::VAL_W-1:0]          o_final_re,
    output logic signed [mbet_pkg::VAL_W-1:0]          o_final_im
);
    import mbet_pkg::*;

    localparam int PROD_W    = COORD_BITS + STEP_W;
    localparam int ESC_SHIFT = 2 * FRAC_BITS + 3;   // |z|^2 >= 8 in squared scale

    logic [PROD_W-1:0]         r_off_re, r_off_im;
    logic signed [VAL_W-1:0]   r_cre, r_cim;
    logic signed [VAL_W-1:0]   r_zr, r_zi;
    logic signed [PROD_FW-1:0] r_rr, r_ii, r_ri;
    logic [ITER_W-1:0]         r_iter;

    logic                      r_res_inside;
    logic [ITER_W-1:0]         r_res_iter;
    logic signed [VAL_W-1:0]   r_res_re, r_res_im;

    logic signed [SAT_W-1:0]   w_cre_sum, w_cim_sum;
    logic signed [PROD_FW-1:0] w_diff;
    logic signed [SAT_W-1:0]   w_nr_sum, w_ni_sum;
    logic [PROD_FW:0]          w_mag;
    logic                      w_escaped;

    assign w_cre_sum = SAT_W'(i_origin_re)
                     + $signed({{(SAT_W-PROD_W){1'b0}}, r_off_re});
    assign w_cim_sum = SAT_W'(i_origin_im)
                     - $signed({{(SAT_W-PROD_W){1'b0}}, r_off_im});

    // floor shifts are arithmetic right shifts of the exact products
    assign w_diff   = r_rr - r_ii;
    assign w_nr_sum = SAT_W'(w_diff >>> FRAC_BITS) + SAT_W'(r_cre);
    assign w_ni_sum = SAT_W'(r_ri >>> (FRAC_BITS - 1)) + SAT_W'(r_cim);

    // squares are never negative, so the sum is taken unsigned
    assign w_mag     = {1'b0, r_rr} + {1'b0, r_ii};
    assign w_escaped = |(w_mag >> ESC_SHIFT);

    assign o_sts.escaped  = w_escaped;
    assign o_sts.at_limit = (r_iter == i_max_iter);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_off_re <= PROD_W'(i_pixel_x) * PROD_W'(i_step_re);
            r_off_im <= PROD_W'(i_pixel_y) * PROD_W'(i_step_im);
        end
        if (i_cmd.seed) begin
            r_cre  <= sat_val(w_cre_sum);
            r_cim  <= sat_val(w_cim_sum);
            r_zr   <= '0;
            r_zi   <= '0;
            r_iter <= '0;
        end
        if (i_cmd.mul) begin
            r_rr <= r_zr * r_zr;
            r_ii <= r_zi * r_zi;
            r_ri <= r_zr * r_zi;
        end
        if (i_cmd.step) begin
            r_zr   <= sat_val(w_nr_sum);
            r_zi   <= sat_val(w_ni_sum);
            r_iter <= r_iter + 1'b1;
        end
        if (i_cmd.publish) begin
            r_res_inside <= !w_escaped;
            r_res_iter   <= r_iter;
            r_res_re     <= r_zr;
            r_res_im     <= r_zi;
        end
    end

    assign o_inside_res = r_res_inside;
    assign o_iterations = r_res_iter;
    assign o_final_re   = r_res_re;
    assign o_final_im   = r_res_im;

endmodule

`default_nettype wire

// File: rtl/mandelbrot_escape_time_unit.sv
// Top level of the Mandelbrot escape-time unit: ports, registers, sequencer and datapath.
`default_nettype none

// One word on the slave side carries a pixel (column, row); the unit maps it to
// c = (origin_re + x*step_re) + i(origin_im - y*step_im), each part clamped to the
// signed 32-bit range, then runs z = z*z + c from z = 0 in saturating fixed point
// with FRAC_BITS fraction bits (Q5.27 by default) until |z|^2 >= 8 or max_iter
// updates have run. One result word follows each pixel: tuser flags a point that
// never escaped, tdata holds the iteration count (escape iteration, or max_iter
// when inside; 0 when max_iter is 0) and the last z. One pixel is worked on at a
// time. The single z update alternates a product stage (three 32x32 multipliers)
// and an update/escape stage, so the time from accepting a pixel until the next
// one can be taken grows with its reported iteration count and with any wait for
// the output register to drain. The finished result waits in an output register,
// so a new pixel is accepted while it is still waiting to be taken; the next
// result is held back until the register drains. Configuration writes go to
// i_cfg_idx / i_cfg_data under i_cfg_we and take effect at once; write them only
// while the unit is idle. Indexes 5 to 7 are ignored.

module mandelbrot_escape_time_unit #(
    parameter int COORD_BITS = mbet_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = mbet_pkg::DEF_FRAC_BITS,
    localparam int IN_W      = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // pixel words
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [IN_W-1:0]                 s_axis_tdata,  // pixel_x, pixel_y, zero pad
    // result words
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [mbet_pkg::OUT_W-1:0]           m_axis_tdata,  // iterations, final_re, final_im
    output logic                                 m_axis_tuser,  // inside_res
    // register writes
    input  wire logic                            i_cfg_we,
    input  wire logic [mbet_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mbet_pkg::CFG_W-1:0]      i_cfg_data
);
    import mbet_pkg::*;

    logic signed [VAL_W-1:0] r_origin_re, r_origin_im;
    logic [STEP_W-1:0]       r_step_re, r_step_im;
    logic [ITER_W-1:0]       r_max_iter;

    t_dp_cmd                 w_cmd;
    t_dp_sts                 w_sts;
    logic                    w_inside;
    logic [ITER_W-1:0]       w_iterations;
    logic signed [VAL_W-1:0] w_final_re, w_final_im;

    // Register file: written in place, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_re <= RST_ORIGIN_RE;
            r_origin_im <= RST_ORIGIN_IM;
            r_step_re   <= RST_STEP_RE;
            r_step_im   <= RST_STEP_IM;
            r_max_iter  <= RST_MAX_ITER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN_RE: r_origin_re <= i_cfg_data[VAL_W-1:0];
                CFG_ORIGIN_IM: r_origin_im <= i_cfg_data[VAL_W-1:0];
                CFG_STEP_RE:   r_step_re   <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_IM:   r_step_im   <= i_cfg_data[STEP_W-1:0];
                CFG_MAX_ITER:  r_max_iter  <= i_cfg_data[ITER_W-1:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    mbet_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mbet_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_pixel_x    (s_axis_tdata[COORD_BITS-1:0]),
        .i_pixel_y    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_origin_re  (r_origin_re),
        .i_origin_im  (r_origin_im),
        .i_step_re    (r_step_re),
        .i_step_im    (r_step_im),
        .i_max_iter   (r_max_iter),
        .o_inside_res (w_inside),
        .o_iterations (w_iterations),
        .o_final_re   (w_final_re),
        .o_final_im   (w_final_im)
    );

    assign m_axis_tdata = {w_final_im, w_final_re, w_iterations};
    assign m_axis_tuser = w_inside;

    // A result appears only after the datapath reported escape or limit
    a_publish_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_sts.escaped || w_sts.at_limit))
        else $error("result published before the iteration finished");

    // z starts at zero, so an escaped point has run at least one update
    a_escape_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[ITER_W-1:0] != '0))
        else $error("escaped point reports zero iterations");

    // One pixel at a time: after taking a word the input side closes
    a_one_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second pixel taken while one is in flight");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the Mandelbrot escape-time unit: pixel stream in, result check out.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbet_pkg::*;

    localparam int COORD = DEF_COORD_BITS;
    localparam int FRAC  = DEF_FRAC_BITS;
    localparam int PIX_W = ((2 * COORD + 7) / 8) * 8;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    // |z|^2 threshold of 8, in the fraction scale that the squared sum keeps after one shift
    localparam longint unsigned ESC_LIMIT = 64'd8 << FRAC;

    // indexes above the last register are decoded as no-ops
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_MAX_ITER + 3'd1;

    typedef struct {
        logic [COORD-1:0] col;
        logic [COORD-1:0] row;
    } t_pixel;

    typedef struct {
        logic              in_set;
        logic [ITER_W-1:0] iters;
        logic [VAL_W-1:0]  z_re;
        logic [VAL_W-1:0]  z_im;
    } t_escape;

    // clock, reset and block ports
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [PIX_W-1:0]     s_axis_tdata  = '0;    // pixel_x, pixel_y, zero pad
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;          // iterations, final_re, final_im
    logic                 m_axis_tuser;          // inside_res
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = CFG_ORIGIN_RE;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // window and limit as the block should hold them
    longint            win_origin_re = RST_ORIGIN_RE;
    longint            win_origin_im = RST_ORIGIN_IM;
    longint            win_step_re   = RST_STEP_RE;
    longint            win_step_im   = RST_STEP_IM;
    logic [ITER_W-1:0] win_max_iter  = RST_MAX_ITER;

    t_pixel  pending_pixels[$];     // pixels not yet offered to the block
    t_escape expected_escapes[$];   // predictions for accepted pixels, oldest first
    int      mismatch_count = 0;

    // sender pacing
    logic pix_took   = 1'b0;        // the word on the slave side was taken at the last rising edge
    int   burst_left = 1;
    int   gap_left   = 0;

    // receiver pacing
    int        stall_left = 0;
    logic [10:0] rx_phase = '0;

    always #6 i_clk = ~i_clk;

    mandelbrot_escape_time_unit #(
        .COORD_BITS(COORD),
        .FRAC_BITS (FRAC)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    function automatic longint clamp32(input longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // Map the pixel to c, iterate z = z*z + c from zero and stop on escape or at the limit.
    function automatic t_escape escape_time(input logic [COORD-1:0] col,
                                            input logic [COORD-1:0] row);
        longint            px, py, c_re, c_im, zr, zi, nr, ni;
        longint unsigned   sq_re, sq_im;
        int unsigned       n;
        t_escape           r;
        px   = col;
        py   = row;
        c_re = clamp32(win_origin_re + px * win_step_re);
        c_im = clamp32(win_origin_im - py * win_step_im);
        zr = 0;
        zi = 0;
        r.in_set = 1'b1;
        r.iters  = win_max_iter;
        for (n = 1; n <= win_max_iter; n++) begin
            // floor division by the scale: arithmetic shift on the exact 64-bit products
            nr = clamp32(((zr * zr - zi * zi) >>> FRAC) + c_re);
            ni = clamp32(((zr * zi) >>> (FRAC - 1)) + c_im);
            zr = nr;
            zi = ni;
            sq_re = zr * zr;
            sq_im = zi * zi;
            if (((sq_re + sq_im) >> FRAC) >= ESC_LIMIT) begin
                r.in_set = 1'b0;
                r.iters  = n[ITER_W-1:0];
                break;
            end
        end
        r.z_re = zr[VAL_W-1:0];
        r.z_im = zi[VAL_W-1:0];
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
        mismatch_count++;
        $display("%0t ns: %s: got 0x%08h, want 0x%08h", $time, what, got, want);
    endtask

    // Write one register at a falling edge; keep the local copy in step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_ORIGIN_RE: win_origin_re = $signed(data);
            CFG_ORIGIN_IM: win_origin_im = $signed(data);
            CFG_STEP_RE:   win_step_re   = data[STEP_W-1:0];
            CFG_STEP_IM:   win_step_im   = data[STEP_W-1:0];
            CFG_MAX_ITER:  win_max_iter  = data[ITER_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_pixel(input int col, input int row);
        t_pixel p;
        p.col = col[COORD-1:0];
        p.row = row[COORD-1:0];
        pending_pixels.push_back(p);
    endtask

    task automatic queue_random(input int count);
        for (int k = 0; k < count; k++)
            queue_pixel($urandom_range(0, (1 << COORD) - 1), $urandom_range(0, (1 << COORD) - 1));
    endtask

    // Hold until every pixel has been taken and every result checked, then let the unit settle.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_pixels.size() != 0 || s_axis_tvalid || expected_escapes.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // A window that covers the set: left edge in [-2.5, -0.5], top edge in [0.5, 1.5],
    // steps so that the full pixel range spans a width of 0.5 to 4.
    task automatic set_view(input logic [ITER_W-1:0] iters);
        logic [CFG_W-1:0] left;
        left = $urandom_range(0, 268435456);
        left = left - 32'd335544320;
        write_reg(CFG_MAX_ITER, {16'h0000, iters});
        write_reg(CFG_STEP_IM, $urandom_range(16384, 131072));
        write_reg(CFG_ORIGIN_RE, left);
        write_reg(CFG_STEP_RE, $urandom_range(16384, 131072));
        write_reg(CFG_ORIGIN_IM, $urandom_range(67108864, 201326592));
    endtask

    // Arbitrary register words, unused high bits set at random; mostly far-out points.
    task automatic set_wild(input logic [ITER_W-1:0] iters);
        write_reg(CFG_ORIGIN_RE, $urandom);
        write_reg(CFG_ORIGIN_IM, $urandom);
        write_reg(CFG_STEP_RE, $urandom);
        write_reg(CFG_STEP_IM, $urandom);
        write_reg(CFG_MAX_ITER, {16'($urandom_range(0, 65535)), iters});
    endtask

    // Sender: offer pending pixels in bursts of random length, with random gaps between.
    always @(negedge i_clk) begin : pixel_driver
        t_pixel nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !pix_took) begin
            // hold the word until it is taken
        end else if (gap_left > 0) begin
            s_axis_tvalid <= 1'b0;
            gap_left--;
        end else if (pending_pixels.size() != 0) begin
            nxt = pending_pixels.pop_front();
            s_axis_tdata  <= PIX_W'({nxt.row, nxt.col});
            s_axis_tvalid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 16);
                // a quarter of the bursts run straight into the next one
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: alternate windows of constant readiness and of random stalls, switched by rx_phase[10].
    always @(negedge i_clk) begin
        rx_phase <= rx_phase + 11'd1;
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (rx_phase[10] && $urandom_range(0, 3) == 0)
                stall_left <= $urandom_range(1, 30);
        end
    end

    // Predict on each accepted pixel, check each accepted result against the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_escape want;
        pix_took <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                expected_escapes.push_back(escape_time(s_axis_tdata[COORD-1:0],
                                                       s_axis_tdata[2*COORD-1:COORD]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_escapes.size() == 0) begin
                    note_mismatch("result word with no pixel pending",
                                  m_axis_tdata[VAL_W-1:0], '0);
                end else begin
                    want = expected_escapes.pop_front();
                    if (m_axis_tuser !== want.in_set)
                        note_mismatch("inside flag", VAL_W'(m_axis_tuser),
                                      VAL_W'(want.in_set));
                    if (m_axis_tdata[ITER_W-1:0] !== want.iters)
                        note_mismatch("iteration count", VAL_W'(m_axis_tdata[ITER_W-1:0]),
                                      VAL_W'(want.iters));
                    if (m_axis_tdata[ITER_W +: VAL_W] !== want.z_re)
                        note_mismatch("final real part", m_axis_tdata[ITER_W +: VAL_W],
                                      want.z_re);
                    if (m_axis_tdata[ITER_W+VAL_W +: VAL_W] !== want.z_im)
                        note_mismatch("final imaginary part",
                                      m_axis_tdata[ITER_W+VAL_W +: VAL_W], want.z_im);
                end
            end
        end
    end

    // Timeout: far beyond the slowest correct run, including the one long inside point.
    initial begin
        #25_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window: left edge -2, top edge 1, 1/512 per pixel, limit 255.
        // Corners, points on the real axis inside the set (-1.5, period-two -1,
        // the cusp 0.25, the tip -2) and points that leave at once.
        queue_pixel(0, 0);
        queue_pixel((1 << COORD) - 1, (1 << COORD) - 1);
        queue_pixel(0, (1 << COORD) - 1);
        queue_pixel((1 << COORD) - 1, 0);
        queue_pixel(256, 512);
        queue_pixel(512, 512);
        queue_pixel(1152, 512);
        queue_pixel(0, 512);
        queue_pixel(1152, 0);
        queue_pixel(2048, 2048);
        wait_drained();

        // Origin at zero: c = 2 - 2i sits exactly on the escape bound, the next
        // column in sits just below it, and c = 0 never moves.
        write_reg(CFG_ORIGIN_RE, 32'd0);
        write_reg(CFG_ORIGIN_IM, 32'd0);
        queue_pixel(1024, 1024);
        queue_pixel(1023, 1024);
        queue_pixel(0, 0);
        wait_drained();

        // Coordinate overflow: drive c_re past the top and c_im past the bottom.
        write_reg(CFG_ORIGIN_RE, 32'h7fff_ffff);
        write_reg(CFG_ORIGIN_IM, 32'h8000_0000);
        write_reg(CFG_STEP_RE, 32'h7fff_ffff);
        write_reg(CFG_STEP_IM, 32'h7fff_ffff);
        write_reg(CFG_MAX_ITER, 32'd1);
        queue_pixel((1 << COORD) - 1, (1 << COORD) - 1);
        queue_pixel(0, 0);
        queue_pixel(1, (1 << COORD) - 1);
        wait_drained();

        // Zero limit: no update runs, z stays at zero and the point counts as inside.
        write_reg(CFG_MAX_ITER, 32'd0);
        queue_pixel(0, 0);
        queue_pixel((1 << COORD) - 1, (1 << COORD) - 1);
        wait_drained();

        // Top limit: one fixed point held for the full count, one quick escape.
        write_reg(CFG_ORIGIN_RE, 32'd0);
        write_reg(CFG_ORIGIN_IM, 32'd0);
        write_reg(CFG_STEP_RE, RST_STEP_RE);
        write_reg(CFG_STEP_IM, RST_STEP_IM);
        write_reg(CFG_MAX_ITER, 32'd65535);
        queue_pixel(0, 0);
        queue_pixel(2048, 0);
        wait_drained();

        // Random part: windows over the set with limits from 1 to 255, and arbitrary words.
        set_view(16'd32);
        queue_random(125);
        wait_drained();             // let the sender sit until the unit has drained
        queue_random(125);
        wait_drained();

        set_wild(16'($urandom_range(1, 20)));
        queue_random(150);
        wait_drained();

        set_view(16'd255);
        queue_random(120);
        wait_drained();

        set_view(16'd1);
        for (int k = 0; k < 3; k++)
            write_reg(CFG_SPARE_LO + k[CFG_IDX_W-1:0], $urandom);
        queue_random(150);
        wait_drained();

        set_wild(16'($urandom_range(1, 100)));
        set_view(16'($urandom_range(2, 64)));
        queue_random(250);
        wait_drained();

        set_view(16'd8);
        queue_random(180);
        wait_drained();

        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0 && expected_escapes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
